/* rtl/pf_pkg.sv */
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and cell lookup for the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int LETTER_W = 5;
    localparam int POS_W    = 3;
    localparam int SIDE     = 5;
    localparam int ROW_W    = LETTER_W * SIDE;
    localparam int CFG_IDX_W = 3;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [ROW_W-1:0]    t_row;
    typedef t_row [SIDE-1:0]     t_square;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW4 = 3'd4;

    // Reset square: alphabet without I, row-major
    localparam t_row ROW0_RST = 25'd4294688;
    localparam t_row ROW1_RST = 25'd10788037;
    localparam t_row ROW2_RST = 25'd16201099;
    localparam t_row ROW3_RST = 25'd21613104;
    localparam t_row ROW4_RST = 25'd27025109;

    // Encrypted digraph
    typedef struct packed {
        t_letter x;
        t_letter y;
    } t_pair;

    // Cell at (row, col); positions are always 0..4
    function automatic t_letter sq_cell(input t_square sq, input t_pos r, input t_pos c);
        t_row row;
        t_letter res;
        case (r)
            3'd0:    row = sq[0];
            3'd1:    row = sq[1];
            3'd2:    row = sq[2];
            3'd3:    row = sq[3];
            default: row = sq[4];
        endcase
        case (c)
            3'd0:    res = row[4:0];
            3'd1:    res = row[9:5];
            3'd2:    res = row[14:10];
            3'd3:    res = row[19:15];
            default: res = row[24:20];
        endcase
        return res;
    endfunction

    // One step down or right, wrapping at the edge
    function automatic t_pos pos_next(input t_pos p);
        return (p == t_pos'(SIDE - 1)) ? '0 : p + t_pos'(1);
    endfunction

endpackage

/* rtl/pf_cipher.sv */
// ----------------------------------------------------------------------------
// pf_cipher
// Encrypts one digraph against the key square: parallel locate, then the
// same-row, same-column or rectangle rule.
// ----------------------------------------------------------------------------
module pf_cipher (
    input  pf_pkg::t_square i_square,
    input  pf_pkg::t_letter i_a,
    input  pf_pkg::t_letter i_b,
    output pf_pkg::t_pair   o_pair
);

    // Last match in row-major order wins; no match gives (0, 0)
    function automatic logic [2*pf_pkg::POS_W-1:0] locate(input pf_pkg::t_square sq,
                                                          input pf_pkg::t_letter l);
        pf_pkg::t_pos r_hit;
        pf_pkg::t_pos c_hit;
        r_hit = '0;
        c_hit = '0;
        for (int r = 0; r < pf_pkg::SIDE; r++) begin
            for (int c = 0; c < pf_pkg::SIDE; c++) begin
                if (sq[r][c*pf_pkg::LETTER_W +: pf_pkg::LETTER_W] == l) begin
                    r_hit = pf_pkg::t_pos'(r);
                    c_hit = pf_pkg::t_pos'(c);
                end
            end
        end
        return {r_hit, c_hit};
    endfunction

    pf_pkg::t_pos ra, ca, rb, cb;

    always_comb begin
        {ra, ca} = locate(i_square, i_a);
        {rb, cb} = locate(i_square, i_b);
        if (ra == rb) begin
            o_pair.x = pf_pkg::sq_cell(i_square, ra, pf_pkg::pos_next(ca));
            o_pair.y = pf_pkg::sq_cell(i_square, rb, pf_pkg::pos_next(cb));
        end else if (ca == cb) begin
            o_pair.x = pf_pkg::sq_cell(i_square, pf_pkg::pos_next(ra), ca);
            o_pair.y = pf_pkg::sq_cell(i_square, pf_pkg::pos_next(rb), cb);
        end else begin
            o_pair.x = pf_pkg::sq_cell(i_square, ra, cb);
            o_pair.y = pf_pkg::sq_cell(i_square, rb, ca);
        end
    end

endmodule

/* rtl/pf_out_ser.sv */
// ----------------------------------------------------------------------------
// pf_out_ser
// Result register: holds one encrypted pair and sends its letters, once or
// twice over, on the output stream.
// ----------------------------------------------------------------------------
module pf_out_ser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  pf_pkg::t_pair   i_pair,
    input  logic            i_twice,
    output logic            o_free,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic            m_axis_tlast    // last_of_run
);

    logic          r_valid;
    pf_pkg::t_pair r_pair;
    logic          r_twice;
    logic [1:0]    r_idx;
    logic          is_last;
    logic          xfer;

    assign is_last = r_idx[0] && (r_idx[1] || !r_twice);
    assign xfer    = r_valid && m_axis_tready;
    assign o_free  = !r_valid || (xfer && is_last);

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b000, r_idx[0] ? r_pair.y : r_pair.x};
    assign m_axis_tlast  = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            r_valid <= !is_last;
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pair  <= i_pair;
            r_twice <= i_twice;
        end
    end

endmodule

/* rtl/playfair_digraph_encrypt_core.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_core
// Playfair encryptor: pairs plaintext letters and streams cipher letters.
// ----------------------------------------------------------------------------
// Letters (A=0..Z=25, I taken as J) enter one per transaction; end_of_text
// (tlast) marks the last letter of a message. An unpaired letter is held
// inside; the next letter completes the digraph, which yields two cipher
// letters. A doubled letter pairs with X and stays held; a message ending
// on an odd letter is padded with X, so one input can yield 0, 2 or 4
// letters, and tlast on the output marks the last letter that one input
// caused. The block takes one letter per cycle while its input register
// is empty or moves on; the output sends one letter per cycle while tready
// is high. A digraph passes the input register, then the result register.
// The key square is five 25-bit row registers (column c at bits 5c+4:5c),
// written through the config channel; indexes above 4 are ignored. The user
// must write it only while the block is idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // plaintext stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] plain_letter, [7:5] unused
    input  logic        s_axis_tlast,   // end_of_text
    // ciphertext stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic        m_axis_tlast,   // last_of_run
    // key square write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pf_pkg::ROW_W-1:0]     i_cfg_data
);

    // key square
    pf_pkg::t_square r_square;

    // pairing state
    logic            r_held_valid;
    pf_pkg::t_letter r_held_letter;
    logic            n_held_valid;
    pf_pkg::t_letter n_held_letter;

    // input register: digraph waiting for encryption
    logic            r_in_valid;
    pf_pkg::t_letter r_a, r_b;
    logic            r_twice;
    pf_pkg::t_letter n_a, n_b;
    logic            n_twice;
    logic            push;

    logic            accept;
    logic            ser_free;
    logic            load_out;
    pf_pkg::t_letter folded;
    pf_pkg::t_pair   pair;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square[0] <= pf_pkg::ROW0_RST;
            r_square[1] <= pf_pkg::ROW1_RST;
            r_square[2] <= pf_pkg::ROW2_RST;
            r_square[3] <= pf_pkg::ROW3_RST;
            r_square[4] <= pf_pkg::ROW4_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pf_pkg::CFG_ROW0: r_square[0] <= i_cfg_data;
                pf_pkg::CFG_ROW1: r_square[1] <= i_cfg_data;
                pf_pkg::CFG_ROW2: r_square[2] <= i_cfg_data;
                pf_pkg::CFG_ROW3: r_square[3] <= i_cfg_data;
                pf_pkg::CFG_ROW4: r_square[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input side takes a letter whenever the input register is empty or moves on
    assign load_out      = r_in_valid && ser_free;
    assign s_axis_tready = !r_in_valid || ser_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign folded = (s_axis_tdata[4:0] == pf_pkg::LETTER_I) ? pf_pkg::LETTER_J
                                                           : s_axis_tdata[4:0];

    // digraph forming
    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        n_a           = r_held_letter;
        n_b           = pf_pkg::LETTER_X;
        n_twice       = 1'b0;
        push          = 1'b1;
        if (!r_held_valid) begin
            n_a = folded;
            if (!s_axis_tlast) begin
                // first of a pair: just hold it
                push          = 1'b0;
                n_held_valid  = 1'b1;
                n_held_letter = folded;
            end
        end else if (r_held_letter != folded) begin
            n_b           = folded;
            n_held_valid  = 1'b0;
            n_held_letter = '0;
        end else if (s_axis_tlast) begin
            // doubled letter at end: same (letter, X) pair goes out twice
            n_twice       = 1'b1;
            n_held_valid  = 1'b0;
            n_held_letter = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
            r_in_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_held_valid  <= n_held_valid;
                r_held_letter <= n_held_letter;
            end
            if (accept && push)
                r_in_valid <= 1'b1;
            else if (load_out)
                r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_twice <= n_twice;
        end
    end

    pf_cipher u_cipher (
        .i_square (r_square),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_pair   (pair)
    );

    pf_out_ser u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load_out),
        .i_pair        (pair),
        .i_twice       (r_twice),
        .o_free        (ser_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // held letter is always folded
    a_held_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_held_letter != pf_pkg::LETTER_I))
        else $error("held letter not folded");

    // end of text always flushes the held letter
    a_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> !r_held_valid)
        else $error("letter still held after end of text");

    // a finished run with nothing queued leaves the output idle
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !r_in_valid) |=> !m_axis_tvalid)
        else $error("output valid without queued digraph");

    // a pending digraph never sits behind an empty result register
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("digraph not moved to result register");

endmodule

/* tb/pf_cipher_checker.sv */
// ----------------------------------------------------------------------------
// pf_cipher_checker
// Watches the plaintext, ciphertext and key square channels of the Playfair
// encryptor, predicts every cipher letter and compares it with the stream.
// ----------------------------------------------------------------------------
module pf_cipher_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [4:0] plain_letter, [7:5] unused
    input  logic                         s_axis_tlast,   // end_of_text
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [7:0]                   m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
    input  logic                         m_axis_tlast,   // last_of_run
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [pf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pf_pkg::ROW_W-1:0]     i_cfg_data,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        pf_pkg::t_letter letter;
        logic            last;
    } t_cipher;

    pf_pkg::t_square key_sq;
    pf_pkg::t_letter held_letter;
    logic            held_valid;
    t_cipher         cipher_due_q[$];
    int              due_count = 0;
    int              checked_count = 0;
    int              mismatch_count = 0;

    assign o_pending = due_count;
    assign o_checked = checked_count;
    assign o_errors  = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic pf_pkg::t_letter square_at(input int r, input int c);
        return key_sq[r][pf_pkg::LETTER_W*c +: pf_pkg::LETTER_W];
    endfunction

    // last match in row-major order wins; no match lands on (0,0)
    function automatic void find_letter(input pf_pkg::t_letter l,
                                        output int row, output int col);
        row = 0;
        col = 0;
        for (int r = 0; r < pf_pkg::SIDE; r++)
            for (int c = 0; c < pf_pkg::SIDE; c++)
                if (square_at(r, c) == l) begin
                    row = r;
                    col = c;
                end
    endfunction

    function automatic void encrypt_digraph(input pf_pkg::t_letter a,
                                            input pf_pkg::t_letter b,
                                            input logic last);
        int ra, ca, rb, cb;
        pf_pkg::t_letter x, y;
        find_letter(a, ra, ca);
        find_letter(b, rb, cb);
        if (ra == rb) begin
            x = square_at(ra, (ca + 1) % pf_pkg::SIDE);
            y = square_at(rb, (cb + 1) % pf_pkg::SIDE);
        end else if (ca == cb) begin
            x = square_at((ra + 1) % pf_pkg::SIDE, ca);
            y = square_at((rb + 1) % pf_pkg::SIDE, cb);
        end else begin
            x = square_at(ra, cb);
            y = square_at(rb, ca);
        end
        cipher_due_q.push_back('{x, 1'b0});
        cipher_due_q.push_back('{y, last});
    endfunction

    always @(posedge i_clk) begin
        pf_pkg::t_letter plain;
        t_cipher want;
        if (!i_rst_n) begin
            key_sq[0]   = pf_pkg::ROW0_RST;
            key_sq[1]   = pf_pkg::ROW1_RST;
            key_sq[2]   = pf_pkg::ROW2_RST;
            key_sq[3]   = pf_pkg::ROW3_RST;
            key_sq[4]   = pf_pkg::ROW4_RST;
            held_letter = '0;
            held_valid  = 1'b0;
            cipher_due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && int'(i_cfg_index) < pf_pkg::SIDE)
                key_sq[i_cfg_index] = i_cfg_data;

            if (s_axis_tvalid && s_axis_tready) begin
                plain = s_axis_tdata[pf_pkg::LETTER_W-1:0];
                if (plain == pf_pkg::LETTER_I)
                    plain = pf_pkg::LETTER_J;
                if (!held_valid) begin
                    if (s_axis_tlast) begin
                        encrypt_digraph(plain, pf_pkg::LETTER_X, 1'b1);
                    end else begin
                        held_letter = plain;
                        held_valid  = 1'b1;
                    end
                end else if (held_letter != plain) begin
                    encrypt_digraph(held_letter, plain, 1'b1);
                    held_letter = '0;
                    held_valid  = 1'b0;
                end else if (s_axis_tlast) begin
                    encrypt_digraph(held_letter, pf_pkg::LETTER_X, 1'b0);
                    encrypt_digraph(plain, pf_pkg::LETTER_X, 1'b1);
                    held_letter = '0;
                    held_valid  = 1'b0;
                end else begin
                    // doubled letter: pair with X, the new one stays held
                    encrypt_digraph(held_letter, pf_pkg::LETTER_X, 1'b1);
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_due_q.size() == 0) begin
                    report_mismatch($sformatf("cipher letter %0d with nothing due",
                                              m_axis_tdata[pf_pkg::LETTER_W-1:0]));
                end else begin
                    want = cipher_due_q.pop_front();
                    checked_count++;
                    if (m_axis_tdata[pf_pkg::LETTER_W-1:0] != want.letter)
                        report_mismatch($sformatf("cipher_letter got %0d want %0d",
                                                  m_axis_tdata[pf_pkg::LETTER_W-1:0],
                                                  want.letter));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last_of_run got %b want %b",
                                                  m_axis_tlast, want.last));
                    if (m_axis_tdata[7:pf_pkg::LETTER_W] != '0)
                        report_mismatch($sformatf("tdata pad bits got %b",
                                                  m_axis_tdata[7:pf_pkg::LETTER_W]));
                end
            end
        end
        due_count <= cipher_due_q.size();
    end

endmodule

/* tb/tb_playfair_digraph_encrypt_core.sv */
// ----------------------------------------------------------------------------
// tb_playfair_digraph_encrypt_core
// Stimulus and verdict for the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
// A short directed run on the reset square hits same row, same column,
// rectangle, doubled letters, X padding, I folding and unmatched codes.
// Random messages then run against shuffled, junk and duplicate-cell key
// squares, with random idle on both stream sides. pf_cipher_checker does
// all prediction and comparison; this module only drives and decides.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_encrypt_core;
    timeunit 1ns;
    timeprecision 1ps;

    // index above the five rows: the block must ignore it
    localparam logic [pf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;   // [4:0] plain_letter, [7:5] unused
    logic                         s_axis_tlast = 1'b0; // end_of_text
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [7:0]                   m_axis_tdata;        // [4:0] cipher_letter, [7:5] zero
    logic                         m_axis_tlast;        // last_of_run
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [pf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    pf_pkg::t_row                 i_cfg_data = '0;

    int pending;
    int letters_checked;
    int errors;
    int letters_sent = 0;
    int send_idle_pct = 33;
    int recv_idle_pct = 84;

    playfair_digraph_encrypt_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pf_cipher_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_checked     (letters_checked),
        .o_errors      (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Idle profile follows progress: sender light / receiver heavy, then
    // swapped, then full rate on both sides.
    task automatic send_plain(input pf_pkg::t_letter letter, input logic eot);
        if (letters_sent < 95) begin
            send_idle_pct = 33;
            recv_idle_pct = 84;
        end else if (letters_sent < 190) begin
            send_idle_pct = 84;
            recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        // valid only drops once a gap is chosen, never twice in one step
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, letter};
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        letters_sent++;
    endtask

    // pending from the checker is registered, so wait for the next edge before looking
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // stop the sender, let every due letter come out, then wait out the input
    // and result registers in case a letter is still in flight
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pf_pkg::CFG_IDX_W-1:0] idx,
                             input pf_pkg::t_row data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_square(input pf_pkg::t_square sq);
        write_reg(pf_pkg::CFG_ROW0, sq[0]);
        write_reg(pf_pkg::CFG_ROW1, sq[1]);
        write_reg(pf_pkg::CFG_ROW2, sq[2]);
        write_reg(pf_pkg::CFG_ROW3, sq[3]);
        write_reg(pf_pkg::CFG_ROW4, sq[4]);
    endtask

    // 25 letters without I in random order
    function automatic pf_pkg::t_square shuffled_square();
        pf_pkg::t_letter codes[25];
        pf_pkg::t_letter tmp;
        pf_pkg::t_square sq;
        int n, j;
        n = 0;
        for (int k = 0; k < 26; k++)
            if (pf_pkg::t_letter'(k) != pf_pkg::LETTER_I) begin
                codes[n] = pf_pkg::t_letter'(k);
                n++;
            end
        for (int k = 24; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = codes[k];
            codes[k] = codes[j];
            codes[j] = tmp;
        end
        for (int k = 0; k < 25; k++)
            sq[k / 5][pf_pkg::LETTER_W*(k % 5) +: pf_pkg::LETTER_W] = codes[k];
        return sq;
    endfunction

    // One message of random letters. Doubles, I, X and out-of-range codes
    // are weighted up so the awkward paths run often.
    task automatic send_message(input int len);
        pf_pkg::t_letter prev;
        pf_pkg::t_letter letter;
        int pick;
        prev = '0;
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (k > 0 && pick < 20)
                letter = prev;
            else if (pick < 26)
                letter = pf_pkg::LETTER_I;
            else if (pick < 31)
                letter = pf_pkg::t_letter'($urandom_range(26, 31));
            else if (pick < 37)
                letter = pf_pkg::LETTER_X;
            else
                letter = pf_pkg::t_letter'($urandom_range(0, 25));
            send_plain(letter, k == len - 1);
            prev = letter;
        end
    endtask

    task automatic send_until(input int target);
        while (letters_sent < target)
            send_message($urandom_range(1, 12));
    endtask

    initial begin
        pf_pkg::t_square sq;
        int src, dst;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset square (A..E / F G H J K / L..P / Q..U / V..Z)
        send_plain(5'd0,  1'b0); send_plain(5'd1,  1'b0);  // same row
        send_plain(5'd0,  1'b0); send_plain(5'd5,  1'b0);  // same column
        send_plain(5'd1,  1'b0); send_plain(5'd25, 1'b0);  // rectangle
        send_plain(5'd4,  1'b0); send_plain(5'd4,  1'b1);  // double at end: 4 letters
        send_plain(5'd8,  1'b0); send_plain(5'd9,  1'b0);  // I folds to J, doubles
        send_plain(5'd25, 1'b1);                           // held J pairs with Z
        send_plain(5'd17, 1'b1);                           // lone letter padded with X
        send_plain(pf_pkg::LETTER_X, 1'b0);                // X with X
        send_plain(pf_pkg::LETTER_X, 1'b1);
        send_plain(5'd26, 1'b0); send_plain(5'd31, 1'b0);  // codes not in square
        send_plain(5'd30, 1'b1);
        send_plain(5'd25, 1'b1);                           // top letter alone
        send_plain(5'd12, 1'b0); send_plain(5'd12, 1'b0);  // double mid-message
        send_plain(5'd13, 1'b1);
        send_plain(5'd16, 1'b0); send_plain(5'd8,  1'b1);  // I after held letter

        // ---- shuffled square, plus a write the block must ignore
        drain_pause();
        write_square(shuffled_square());
        write_reg(CFG_SPARE, '1);
        send_until(115);

        // ---- extremes: an all-zero row, an all-ones row, random junk
        drain_pause();
        sq[0] = '0;
        sq[1] = '1;
        sq[2] = pf_pkg::t_row'($urandom);
        sq[3] = pf_pkg::t_row'($urandom);
        sq[4] = pf_pkg::t_row'($urandom);
        write_square(sq);
        send_until(145);
        drain_pause();   // sender holds off until every due letter is out
        send_until(170);

        // ---- duplicate cells: later copy wins the lookup
        drain_pause();
        sq = shuffled_square();
        repeat (6) begin
            src = $urandom_range(0, 24);
            dst = $urandom_range(0, 24);
            sq[dst / 5][pf_pkg::LETTER_W*(dst % 5) +: pf_pkg::LETTER_W] =
                sq[src / 5][pf_pkg::LETTER_W*(src % 5) +: pf_pkg::LETTER_W];
        end
        write_square(sq);
        send_until(215);

        // ---- fresh shuffled square, full-rate tail
        drain_pause();
        write_square(shuffled_square());
        send_until(255);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("summary: %0d plaintext letters sent, %0d cipher letters checked",
                 letters_sent, letters_checked);
        $display("summary: reset, shuffled, junk, duplicate squares; doubles, pads, I folding");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("watchdog expired, %0d cipher letters still due", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/pf_pkg.sv
rtl/pf_cipher.sv
rtl/pf_out_ser.sv
rtl/playfair_digraph_encrypt_core.sv
tb/pf_cipher_checker.sv
tb/tb_playfair_digraph_encrypt_core.sv
